[sv/hbs_pkg.sv]
// hbs_pkg: shared types, codes and constants of the height map box smoother
// no dependencies; imported by every module of the block
package hbs_pkg;

    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_KERNEL_SIZE   = 5;
    localparam int DEF_PENDING_DEPTH = 16;

    localparam int CFG_W    = 9;
    localparam int COORD_W  = 8;
    localparam int HEIGHT_W = 16;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 5;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_PAINT  = 2'd1,
        REQ_COMMIT = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_RANGE     = 3'd1,
        ST_FULL      = 3'd2,
        ST_LOADED    = 3'd3,
        ST_COMMITTED = 3'd4
    } status_t;

    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIN_RD,
        S_WIN_ACC,
        S_DIV,
        S_QUEUE,
        S_CMT_RD,
        S_CMT_WAIT,
        S_CMT_WR,
        S_DONE
    } state_t;

    // divider request bundle
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
    } div_req_t;

endpackage

[sv/hbs_divider.sv]
// hbs_divider: restoring divider, one quotient bit per cycle
// depends on hbs_pkg for the request bundle
module hbs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  hbs_pkg::div_req_t req,
    output logic              done,
    output logic [31:0]       quot
);
    import hbs_pkg::*;

    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;

    // load on start, then one shift-subtract step per cycle while busy
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[15:0], q_reg[31]};
        if (req.start)
        begin
            q_next    = req.num;
            r_next    = '0;
            d_next    = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !req.start) |=> !done_reg)
        else $error("divider done without work");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not start");
endmodule

[sv/heightmap_box_smoother.sv]
// Height map box smoother. One start at a time; busy is high while an item
// is in work and a result appears on done for one cycle, which the receiver
// must take. A paint reads the height memory once per window cell, in a read
// state and an accumulate state, then runs a 32-step divider and writes the
// queue; a commit reads and writes back each pending entry in turn. The height
// memory has one port and a registered read.
module heightmap_box_smoother #(
    parameter int MAX_WIDTH     = hbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = hbs_pkg::DEF_MAX_HEIGHT,
    parameter int KERNEL_SIZE   = hbs_pkg::DEF_KERNEL_SIZE,
    parameter int PENDING_DEPTH = hbs_pkg::DEF_PENDING_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [hbs_pkg::COORD_W-1:0] paint_x,
    input  logic [hbs_pkg::COORD_W-1:0] paint_y,
    input  logic [15:0]                 load_value,
    output logic                        done,
    output logic [2:0]                  status,
    output logic [15:0]                 mean_height,
    output logic [4:0]                  pending_level,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [hbs_pkg::CFG_W-1:0]   cfg_data
);
    import hbs_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int AW   = XW + YW;
    localparam int OFF  = KERNEL_SIZE / 2;
    localparam int PW   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW   = $clog2(PENDING_DEPTH + 1);

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    logic [12:0] eff_w, eff_h;
    assign eff_w = (13'(width_reg) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_reg);
    assign eff_h = (13'(height_reg) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_reg);

    // item registers
    state_t state_reg, state_next;
    logic [1:0]  req_reg;
    logic [12:0] px_reg, py_reg;
    logic [15:0] val_reg;
    logic [12:0] xs_reg, xe_reg, ye_reg, cx_reg, cy_reg;
    logic [31:0] sum_reg;
    logic [15:0] cnt_reg;
    logic [CW-1:0] pcount_reg;
    logic [CW-1:0] ci_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [15:0] mean_reg;

    // height memory, one port
    logic [15:0] hmem [0:(1<<AW)-1];
    logic [15:0] hrd_reg;
    logic        hwe;
    logic [AW-1:0] haddr;
    logic [15:0] hwdata;

    always_ff @(posedge clk)
    begin
        if (hwe)
            hmem[haddr] <= hwdata;
        hrd_reg <= hmem[haddr];
    end

    // pending list memory: {y, x, mean}
    localparam int PEW = XW + YW + 16;
    logic [PEW-1:0] pmem [0:PENDING_DEPTH-1];
    logic [PEW-1:0] prd_reg;
    logic           pwe;
    logic [PW-1:0]  paddr;
    always_ff @(posedge clk)
    begin
        if (pwe)
            pmem[paddr] <= {py_reg[YW-1:0], px_reg[XW-1:0], mean_reg};
        prd_reg <= pmem[paddr];
    end

    // divider
    div_req_t dreq;
    logic        ddone;
    logic [31:0] quot;
    hbs_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (ddone),
        .quot (quot)
    );

    // window totals including the cell read this cycle
    logic [31:0] win_sum;
    logic [15:0] win_cnt;
    assign win_sum = sum_reg + 32'(hrd_reg);
    assign win_cnt = cnt_reg + 16'd1;

    logic accept;
    assign accept = start && (state_reg == S_IDLE) && (req_type != REQ_NONE);
    logic inside_in;
    assign inside_in = (13'(paint_x) < eff_w) && (13'(paint_y) < eff_h);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (req_type == REQ_PAINT && inside_in
                        && pcount_reg < CW'(PENDING_DEPTH))
                        state_next = S_WIN_RD;
                    else if (req_type == REQ_COMMIT && pcount_reg != '0)
                        state_next = S_CMT_RD;
                    else
                        state_next = S_DONE;
                end
            S_WIN_RD:   state_next = S_WIN_ACC;
            S_WIN_ACC:
                if (cx_reg == xe_reg && cy_reg == ye_reg)
                    state_next = S_DIV;
                else
                    state_next = S_WIN_RD;
            S_DIV:      if (ddone) state_next = S_QUEUE;
            S_QUEUE:    state_next = S_IDLE;
            S_CMT_RD:   state_next = S_CMT_WAIT;
            S_CMT_WAIT: state_next = S_CMT_WR;
            S_CMT_WR:
                if (ci_reg + CW'(1) == pcount_reg)
                    state_next = S_DONE;
                else
                    state_next = S_CMT_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb
    begin
        hwe    = 1'b0;
        haddr  = {cy_reg[YW-1:0], cx_reg[XW-1:0]};
        hwdata = val_reg;
        pwe    = 1'b0;
        paddr  = ci_reg[PW-1:0];
        dreq.start = 1'b0;
        dreq.num   = win_sum + 32'(win_cnt >> 1);
        dreq.den   = win_cnt;
        unique case (state_reg)
            S_DONE:
                if (req_reg == REQ_LOAD && status_reg == ST_LOADED)
                begin
                    hwe   = 1'b1;
                    haddr = {py_reg[YW-1:0], px_reg[XW-1:0]};
                end
            S_WIN_ACC:
                dreq.start = (cx_reg == xe_reg && cy_reg == ye_reg);
            S_QUEUE:
            begin
                pwe   = 1'b1;
                paddr = pcount_reg[PW-1:0];
            end
            S_CMT_WR:
            begin
                hwe    = 1'b1;
                haddr  = prd_reg[PEW-1:16];
                hwdata = prd_reg[15:0];
            end
            default: ;
        endcase
    end

    logic [12:0] xs_c, xe_c, ys_c, ye_c;
    always_comb
    begin
        xs_c = (13'(paint_x) > 13'(OFF)) ? 13'(paint_x) - 13'(OFF) : '0;
        ys_c = (13'(paint_y) > 13'(OFF)) ? 13'(paint_y) - 13'(OFF) : '0;
        xe_c = (13'(paint_x) + 13'(OFF) < eff_w - 13'd1) ? 13'(paint_x) + 13'(OFF)
                                                          : eff_w - 13'd1;
        ye_c = (13'(paint_y) + 13'(OFF) < eff_h - 13'd1) ? 13'(paint_y) + 13'(OFF)
                                                          : eff_h - 13'd1;
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pcount_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE) || (state_reg == S_QUEUE);
            if (state_reg == S_QUEUE)
                pcount_reg <= pcount_reg + CW'(1);
            else if (state_reg == S_DONE && req_reg == REQ_COMMIT)
                pcount_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            px_reg  <= 13'(paint_x);
            py_reg  <= 13'(paint_y);
            val_reg <= load_value;
            xs_reg  <= xs_c;
            xe_reg  <= xe_c;
            ye_reg  <= ye_c;
            cx_reg  <= xs_c;
            cy_reg  <= ys_c;
            sum_reg <= '0;
            cnt_reg <= '0;
            ci_reg  <= '0;
            mean_reg <= '0;
            if (req_type == REQ_LOAD)
                status_reg <= inside_in ? ST_LOADED : ST_RANGE;
            else if (req_type == REQ_PAINT)
                status_reg <= !inside_in ? ST_RANGE
                            : (pcount_reg >= CW'(PENDING_DEPTH)) ? ST_FULL : ST_QUEUED;
            else
                status_reg <= ST_COMMITTED;
        end
        if (state_reg == S_WIN_ACC)
        begin
            sum_reg <= win_sum;
            cnt_reg <= win_cnt;
            if (cx_reg == xe_reg)
            begin
                cx_reg <= xs_reg;
                cy_reg <= cy_reg + 13'd1;
            end
            else
                cx_reg <= cx_reg + 13'd1;
        end
        if (state_reg == S_DIV && ddone)
            mean_reg <= quot[15:0];
        if (state_reg == S_CMT_WR)
            ci_reg <= ci_reg + CW'(1);
    end

    // result
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign mean_height   = mean_reg;
    assign pending_level = 5'(pcount_reg);

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= CW'(PENDING_DEPTH))
        else $error("pending count overflow");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result held two cycles");
    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_COMMITTED) |-> pcount_reg == '0)
        else $error("commit left entries");
endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench of the height map box smoother
// depends on hbs_pkg and heightmap_box_smoother; drives directed and random
// load / paint / commit / none beats and checks every result against an in-bench model
`timescale 1ns / 100ps

module tb_top;
    import hbs_pkg::*;

    localparam int MAP_DIM  = 256;
    localparam int KOFF     = 2;
    localparam int PEND_MAX = 16;
    localparam int N_PHASE  = 11;

    typedef struct {
        status_t     st;
        logic [15:0] mean;
        logic [4:0]  level;
    } smooth_res_t;

    typedef struct {
        req_t        req;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] val;
        bit          typed;
        status_t     st;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] req_type;
    logic [7:0] paint_x;
    logic [7:0] paint_y;
    logic [15:0] load_value;
    logic done;
    logic [2:0] status;
    logic [15:0] mean_height;
    logic [4:0] pending_level;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // shadow of the block state
    logic [15:0] shadow_map [0:MAP_DIM*MAP_DIM-1];
    bit          cell_loaded [0:MAP_DIM*MAP_DIM-1];
    logic [7:0]  pend_x [0:PEND_MAX-1];
    logic [7:0]  pend_y [0:PEND_MAX-1];
    logic [15:0] pend_mean [0:PEND_MAX-1];
    int          pend_cnt;
    logic [8:0]  cols_cfg;
    logic [8:0]  rows_cfg;

    smooth_res_t result_queue [$];
    int  mismatches;
    int  beats_sent;
    int  status_seen [0:7];
    bit  allow_gaps;

    heightmap_box_smoother DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .paint_x(paint_x), .paint_y(paint_y),
        .load_value(load_value), .done(done), .status(status),
        .mean_height(mean_height), .pending_level(pending_level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // run limit
    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int cols_eff();
        return (cols_cfg > MAP_DIM) ? MAP_DIM : int'(cols_cfg);
    endfunction

    function automatic int rows_eff();
        return (rows_cfg > MAP_DIM) ? MAP_DIM : int'(rows_cfg);
    endfunction

    // clipped window mean, rounded half up
    function automatic logic [15:0] box_mean(input int px, input int py);
        int xs, ys, xe, ye, cnt;
        logic [31:0] acc;
        xs = (px > KOFF) ? px - KOFF : 0;
        ys = (py > KOFF) ? py - KOFF : 0;
        xe = (px + KOFF < cols_eff() - 1) ? px + KOFF : cols_eff() - 1;
        ye = (py + KOFF < rows_eff() - 1) ? py + KOFF : rows_eff() - 1;
        acc = 0;
        cnt = 0;
        for (int yy = ys; yy <= ye; yy++)
            for (int xx = xs; xx <= xe; xx++)
            begin
                acc += shadow_map[yy*MAP_DIM + xx];
                cnt++;
            end
        if (cnt == 0)
            return 16'd0;
        return 16'((acc + cnt/2) / cnt);
    endfunction

    // advance the shadow state by one accepted beat
    task automatic smooth_predict(input req_t rq, input int px, input int py,
                                  input logic [15:0] val, output bit has_res,
                                  output smooth_res_t r);
        bit in_map;
        in_map = (px < cols_eff()) && (py < rows_eff());
        has_res = 1'b1;
        r.mean = 16'd0;
        case (rq)
            REQ_LOAD:
                if (in_map)
                begin
                    shadow_map[py*MAP_DIM + px] = val;
                    cell_loaded[py*MAP_DIM + px] = 1'b1;
                    r.st = ST_LOADED;
                end
                else
                    r.st = ST_RANGE;
            REQ_PAINT:
                if (!in_map)
                    r.st = ST_RANGE;
                else if (pend_cnt >= PEND_MAX)
                    r.st = ST_FULL;
                else
                begin
                    r.mean = box_mean(px, py);
                    pend_x[pend_cnt] = 8'(px);
                    pend_y[pend_cnt] = 8'(py);
                    pend_mean[pend_cnt] = r.mean;
                    pend_cnt++;
                    r.st = ST_QUEUED;
                end
            REQ_COMMIT:
            begin
                for (int i = 0; i < pend_cnt; i++)
                begin
                    shadow_map[pend_y[i]*MAP_DIM + pend_x[i]] = pend_mean[i];
                    cell_loaded[pend_y[i]*MAP_DIM + pend_x[i]] = 1'b1;
                end
                pend_cnt = 0;
                r.st = ST_COMMITTED;
            end
            default:
                has_res = 1'b0;
        endcase
        r.level = 5'(pend_cnt);
    endtask

    // one start beat; called and returns at a falling edge
    task automatic send_beat(input req_t rq, input logic [7:0] px, input logic [7:0] py,
                             input logic [15:0] val, input bit typed, input status_t tst);
        bit has_res;
        smooth_res_t r;
        int gap;
        req_type = rq;
        paint_x = px;
        paint_y = py;
        load_value = val;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        smooth_predict(rq, px, py, val, has_res, r);
        beats_sent++;
        if (has_res)
        begin
            if (typed)
            begin
                r.st = tst;
                r.mean = 16'd0;
            end
            result_queue.insert(result_queue.size(), r);
        end
        @(negedge clk);
        if (allow_gaps && $urandom_range(0, 99) < 22)
        begin
            start = 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
    endtask

    // a paint that would be queued must only see loaded cells
    task automatic paint_point(input logic [7:0] px, input logic [7:0] py);
        int xs, ys, xe, ye;
        if (px < cols_eff() && py < rows_eff() && pend_cnt < PEND_MAX)
        begin
            xs = (px > KOFF) ? px - KOFF : 0;
            ys = (py > KOFF) ? py - KOFF : 0;
            xe = (px + KOFF < cols_eff() - 1) ? px + KOFF : cols_eff() - 1;
            ye = (py + KOFF < rows_eff() - 1) ? py + KOFF : rows_eff() - 1;
            for (int yy = ys; yy <= ye; yy++)
                for (int xx = xs; xx <= xe; xx++)
                    if (!cell_loaded[yy*MAP_DIM + xx])
                        send_beat(REQ_LOAD, 8'(xx), 8'(yy), 16'($urandom), 1'b0, ST_QUEUED);
        end
        send_beat(REQ_PAINT, px, py, 16'($urandom), 1'b0, ST_QUEUED);
    endtask

    // wait for the block to drain, then write one register
    task automatic write_reg(input logic idx, input logic [8:0] val);
        start = 1'b0;
        while (result_queue.size() != 0 || busy)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IDX_WIDTH)
            cols_cfg = val;
        else
            rows_cfg = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        smooth_res_t e;
        if (rst_n && done)
        begin
            if (result_queue.size() == 0)
                flag_mismatch($sformatf("unexpected result status %0d", status));
            else
            begin
                e = result_queue.pop_front();
                status_seen[e.st]++;
                if (status !== e.st)
                    flag_mismatch($sformatf("status %0d, want %0d", status, e.st));
                if (mean_height !== e.mean)
                    flag_mismatch($sformatf("mean %0d, want %0d", mean_height, e.mean));
                if (pending_level !== e.level)
                    flag_mismatch($sformatf("level %0d, want %0d", pending_level, e.level));
            end
        end
    end

    initial
    begin
        stim_row_t   rows [$];
        logic [8:0]  ph_cols [0:N_PHASE-1];
        logic [8:0]  ph_rows [0:N_PHASE-1];
        int          dice, cw, ch, wait_cnt;
        logic [7:0]  rx, ry;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_LOAD;
        paint_x = '0;
        paint_y = '0;
        load_value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDX_WIDTH;
        cfg_data = '0;
        mismatches = 0;
        beats_sent = 0;
        pend_cnt = 0;
        cols_cfg = 9'd256;
        rows_cfg = 9'd256;
        allow_gaps = 1'b1;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (cell_loaded[i])
            cell_loaded[i] = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // directed beats at the reset map size
        rows = '{
            '{REQ_LOAD,   8'd255, 8'd255, 16'hFFFF, 1'b1, ST_LOADED},
            '{REQ_LOAD,   8'd0,   8'd0,   16'h0000, 1'b1, ST_LOADED},
            '{REQ_COMMIT, 8'd7,   8'd9,   16'h1234, 1'b1, ST_COMMITTED},
            '{REQ_PAINT,  8'd0,   8'd0,   16'h0,    1'b0, ST_QUEUED},
            '{REQ_PAINT,  8'd255, 8'd255, 16'h0,    1'b0, ST_QUEUED},
            '{REQ_PAINT,  8'd2,   8'd2,   16'h0,    1'b0, ST_QUEUED},
            '{REQ_PAINT,  8'd255, 8'd0,   16'h0,    1'b0, ST_QUEUED},
            '{REQ_NONE,   8'd255, 8'd255, 16'hFFFF, 1'b0, ST_QUEUED},
            '{REQ_PAINT,  8'd10,  8'd10,  16'h0,    1'b0, ST_QUEUED},
            '{REQ_PAINT,  8'd10,  8'd10,  16'h0,    1'b0, ST_QUEUED},
            '{REQ_COMMIT, 8'd0,   8'd0,   16'h0,    1'b1, ST_COMMITTED},
            '{REQ_PAINT,  8'd10,  8'd10,  16'h0,    1'b0, ST_QUEUED},
            '{REQ_LOAD,   8'd128, 8'd127, 16'h8000, 1'b1, ST_LOADED},
            '{REQ_LOAD,   8'd127, 8'd128, 16'h7FFF, 1'b1, ST_LOADED}
        };
        foreach (rows[i])
            if (rows[i].req == REQ_PAINT)
                paint_point(rows[i].x, rows[i].y);
            else
                send_beat(rows[i].req, rows[i].x, rows[i].y, rows[i].val,
                          rows[i].typed, rows[i].st);

        // fill the pending list past its depth, then flush
        for (int i = 0; i < PEND_MAX + 2; i++)
            paint_point(8'd100 + 8'(i % 3), 8'd50);
        send_beat(REQ_COMMIT, 8'd0, 8'd0, 16'd0, 1'b1, ST_COMMITTED);

        // map sizes walked by the random part
        ph_cols = '{9'd256, 9'd1,  9'd0, 9'd5, 9'd511, 9'd3, 9'd17, 9'd256, 9'd1,   9'd40, 9'd300};
        ph_rows = '{9'd256, 9'd1,  9'd5, 9'd0, 9'd511, 9'd7, 9'd2,  9'd1,   9'd256, 9'd30, 9'd256};

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            write_reg(CFG_IDX_WIDTH, ph_cols[ph]);
            write_reg(CFG_IDX_HEIGHT, ph_rows[ph]);
            allow_gaps = (ph != 4);
            cw = cols_eff();
            ch = rows_eff();
            for (int n = 0; n < 40; n++)
            begin
                dice = $urandom_range(0, 99);
                if (dice < 15 || cw == 0 || ch == 0)
                begin
                    rx = 8'($urandom);
                    ry = 8'($urandom);
                end
                else if (cw == MAP_DIM && ch == MAP_DIM && dice < 60)
                begin
                    // keep nearly half of the large-map traffic near one corner
                    rx = (ph % 2) ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
                    ry = 8'($urandom_range(0, 15));
                end
                else
                begin
                    rx = 8'($urandom_range(0, cw - 1));
                    ry = 8'($urandom_range(0, ch - 1));
                end
                dice = $urandom_range(0, 99);
                if (dice < 35)
                    send_beat(REQ_LOAD, rx, ry, 16'($urandom), 1'b0, ST_QUEUED);
                else if (dice < 85)
                    paint_point(rx, ry);
                else if (dice < 95)
                    send_beat(REQ_COMMIT, rx, ry, 16'($urandom), 1'b0, ST_QUEUED);
                else
                    send_beat(REQ_NONE, rx, ry, 16'($urandom), 1'b0, ST_QUEUED);
            end
        end
        send_beat(REQ_COMMIT, 8'd0, 8'd0, 16'd0, 1'b1, ST_COMMITTED);
        start = 1'b0;

        // drain
        wait_cnt = 0;
        while (result_queue.size() != 0 && wait_cnt < 10000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (200) @(negedge clk);
        if (result_queue.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", result_queue.size()));

        $display("%0d beats over %0d map sizes; results: queued %0d, out of range %0d,",
                 beats_sent, N_PHASE, status_seen[ST_QUEUED], status_seen[ST_RANGE]);
        $display("dropped %0d, loaded %0d, committed %0d; %0d mismatches",
                 status_seen[ST_FULL], status_seen[ST_LOADED],
                 status_seen[ST_COMMITTED], mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
